### rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg - shared types for the sorted priority queue
// Item formats, operation and status codes, per-cell entry and control.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam logic signed [31:0] EMPTY_DATA = -32'sd1;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] data_in;
    logic [7:0]         priority_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    status_e            status;
    logic [3:0]         occupancy;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [7:0]         prio;
  } entry_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic   enq;       // accepted enqueue, queue not full
    logic   deq;       // accepted dequeue, queue not empty
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

### rtl/core/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted queue
// Compares its entry with the incoming one; keeps, takes the new entry,
// or takes the neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occupied_i,
  input  logic               left_gt_i,
  input  spq_pkg::entry_t    left_entry_i,
  input  spq_pkg::entry_t    right_entry_i,
  output logic               gt_o,
  output spq_pkg::entry_t    entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // empty cells count as larger, so the insert point is the first true one
  assign gt_o = !occupied_i || (entry_q.prio > ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o) begin
        entry_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### rtl/core/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue - bounded priority queue in a chain of sorted cells
// Holds up to DEPTH entries in ascending priority; ties leave in arrival order.
// ----------------------------------------------------------------------------
// One enqueue or dequeue is taken every clock cycle while the input is not
// stalled. Each cell compares its own priority with the incoming one in
// parallel, so an insert or a removal of the head moves every held entry by
// at most one cell at once; the result item enters the output register in
// the cycle after the item is accepted. Input is stalled only while a result
// waits and the output is stalled. No clearing pass follows reset: the entry
// count alone marks which cells hold entries.
module sorted_priority_queue #(
  parameter int DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spq_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spq_pkg::out_item_t  out_item_o
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          in_acc;
  logic          full, empty;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;
  cell_ctrl_t    ctrl;
  entry_t        entries [DEPTH];
  logic          gt [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);

  assign ctrl.enq            = in_acc && (in_item_i.op == OP_ENQ) && !full;
  assign ctrl.deq            = in_acc && (in_item_i.op == OP_DEQ) && !empty;
  assign ctrl.new_entry.data = in_item_i.data_in;
  assign ctrl.new_entry.prio = in_item_i.priority_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occupied;
    logic   left_gt;
    entry_t left_entry, right_entry;

    assign occupied = (CW'(i) < count_q);
    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = ctrl.new_entry;
    end else begin : g_mid
      assign left_gt    = gt[i-1];
      assign left_entry = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied),
      .left_gt_i    (left_gt),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .gt_o         (gt[i]),
      .entry_o      (entries[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_acc) begin
      out_valid_d    = 1'b1;
      out_d.data_out = '0;
      out_d.status   = ST_DONE;
      if (in_item_i.op == OP_ENQ) begin
        if (full) begin
          out_d.status = ST_FULL;
        end
      end else if (empty) begin
        out_d.data_out = EMPTY_DATA;
        out_d.status   = ST_EMPTY;
      end else begin
        out_d.data_out = entries[0].data;
      end
      out_d.occupancy = 4'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.op == OP_ENQ && !full) |=> count_q == $past(count_q) + CW'(1))
    else $error("enqueue did not add an entry");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.op == OP_ENQ && full)
      |=> out_valid_q && out_q.status == ST_FULL && count_q == CW'(DEPTH))
    else $error("full enqueue not reported or state changed");

  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.op == OP_DEQ && empty)
      |=> out_q.data_out == EMPTY_DATA && out_q.status == ST_EMPTY && count_q == '0)
    else $error("empty dequeue result wrong");

endmodule
